[rtl/mirror_port_failover_monitor_unit_defines.svh]
// ----------------------------------------------------------------------------
// Failover monitor assertion macros
// Shared concurrent assertion forms for the failover monitor checkers.
// ----------------------------------------------------------------------------
`ifndef MIRROR_PORT_FAILOVER_MONITOR_UNIT_DEFINES_SVH
`define MIRROR_PORT_FAILOVER_MONITOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPM_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FPM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

[rtl/fpm_pkg.sv]
// ----------------------------------------------------------------------------
// Failover monitor package
// Shared constants and request types of the failover monitor.
// ----------------------------------------------------------------------------
package fpm_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [19:0] UsecPerSec    = 20'd1000000;
  localparam logic [15:0] MaxFrame      = 16'd1518;
  localparam logic [4:0]  MissMax       = 5'd31;
  localparam logic [3:0]  MissLimitInit = 4'd2;

  typedef enum logic {
    CmdRecord = 1'b0,
    CmdTick   = 1'b1
  } cmd_e;

  // Port status after a request
  typedef struct packed {
    logic [1:0] crit;
    logic [1:0] active;
  } stat_t;

  // Classified request from the front to the back
  typedef struct packed {
    logic        fwd;
    logic        iface;
    logic [63:0] stamp;
    logic [15:0] length;
    stat_t       stat;
  } req_t;

endpackage

[rtl/fpm_front.sv]
// ----------------------------------------------------------------------------
// Failover monitor front
// Accepts requests, tracks per-port traffic and failover state, classifies.
// ----------------------------------------------------------------------------
module fpm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              miss_limit_we_i,
  input  logic [3:0]        miss_limit_wdata_i,
  input  logic              take_i,
  input  logic              command_i,
  input  logic              iface_i,
  input  logic [63:0]       record_stamp_i,
  input  logic [15:0]       capture_length_i,
  output fpm_pkg::req_t     req_o
);

  logic [3:0] miss_limit_q;
  logic [1:0] seen_q, seen_d;
  logic [4:0] miss_q [2];
  logic [4:0] miss_d [2];
  logic [1:0] crit_q, crit_d;
  logic [1:0] act_q, act_d;

  always_comb begin
    seen_d    = seen_q;
    miss_d[0] = miss_q[0];
    miss_d[1] = miss_q[1];
    crit_d    = crit_q;
    act_d     = act_q;
    if (fpm_pkg::cmd_e'(command_i) == fpm_pkg::CmdRecord) begin
      seen_d[iface_i] = 1'b1;
    end else begin
      // port 0 first; port 1 sees the outcome of port 0
      for (int p = 0; p < 2; p++) begin
        if (!seen_d[p]) begin
          if (miss_d[p] != fpm_pkg::MissMax) begin
            miss_d[p] = miss_d[p] + 5'd1;
          end
          if (miss_d[p] > {1'b0, miss_limit_q}) begin
            crit_d[p] = 1'b1;
            if (act_d[p] && !crit_d[1-p]) begin
              act_d[p]   = 1'b0;
              act_d[1-p] = 1'b1;
            end
          end
        end else begin
          crit_d[p] = 1'b0;
          miss_d[p] = '0;
          seen_d[p] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    req_o.fwd         = (fpm_pkg::cmd_e'(command_i) == fpm_pkg::CmdRecord) && act_q[iface_i];
    req_o.iface       = iface_i;
    req_o.stamp       = record_stamp_i;
    req_o.length      = capture_length_i;
    req_o.stat.crit   = crit_d;
    req_o.stat.active = act_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_limit_q <= fpm_pkg::MissLimitInit;
      seen_q       <= '0;
      miss_q[0]    <= '0;
      miss_q[1]    <= '0;
      crit_q       <= '0;
      act_q        <= 2'b01;
    end else begin
      if (miss_limit_we_i) begin
        miss_limit_q <= miss_limit_wdata_i;
      end
      if (take_i) begin
        seen_q    <= seen_d;
        miss_q[0] <= miss_d[0];
        miss_q[1] <= miss_d[1];
        crit_q    <= crit_d;
        act_q     <= act_d;
      end
    end
  end

endmodule

[rtl/fpm_queue.sv]
// ----------------------------------------------------------------------------
// Failover monitor request queue
// Small FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
module fpm_queue #(
  parameter int unsigned Depth = fpm_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fpm_pkg::req_t push_req_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          nonempty_o,
  output fpm_pkg::req_t head_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  fpm_pkg::req_t      mem_q [Depth];
  logic [IdxW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    count_q;

  function automatic logic [IdxW-1:0] next_ptr(input logic [IdxW-1:0] ptr);
    next_ptr = (ptr == IdxW'(Depth - 1)) ? '0 : ptr + IdxW'(1);
  endfunction

  assign full_o     = (count_q == CntW'(Depth));
  assign nonempty_o = (count_q != '0);
  assign head_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      priority if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end else begin
        // hold on no traffic or on push and pop together
        count_q <= count_q;
      end
    end
  end

endmodule

[rtl/fpm_back.sv]
// ----------------------------------------------------------------------------
// Failover monitor back end
// Converts timestamps, builds the result and holds it for the receiver.
// ----------------------------------------------------------------------------
module fpm_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  fpm_pkg::req_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          forward_o,
  output logic [1:0]    port_number_o,
  output logic [31:0]   seconds_o,
  output logic [19:0]   microseconds_o,
  output logic [15:0]   data_length_o,
  output logic          oversize_o,
  output fpm_pkg::stat_t stat_o
);

  logic          s1_vld_q, s2_vld_q;
  fpm_pkg::req_t s1_req_q;
  logic [20:0]   s1_prod_q;
  logic [51:0]   prod;
  logic          s1_load, s2_load;
  logic [20:0]   usec_rnd;
  logic          carry;

  assign s2_load = s1_vld_q && (!s2_vld_q || !out_stall_i);
  assign s1_load = !s1_vld_q || s2_load;
  assign pop_o   = head_valid_i && s1_load;

  // fraction times one million; keep the integer part and the rounding bit
  assign prod = 52'(head_i.stamp[31:0]) * 52'(fpm_pkg::UsecPerSec);

  assign usec_rnd = {1'b0, s1_prod_q[20:1]} + 21'(s1_prod_q[0]);
  assign carry    = (usec_rnd >= 21'(fpm_pkg::UsecPerSec));

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_req_q  <= head_i;
      s1_prod_q <= prod[51:31];
    end
    if (s2_load) begin
      stat_o <= s1_req_q.stat;
      if (s1_req_q.fwd) begin
        forward_o      <= 1'b1;
        port_number_o  <= {1'b0, s1_req_q.iface} + 2'd1;
        seconds_o      <= s1_req_q.stamp[63:32] + 32'(carry);
        microseconds_o <= carry ? 20'(usec_rnd - 21'(fpm_pkg::UsecPerSec)) : usec_rnd[19:0];
        data_length_o  <= s1_req_q.length;
        oversize_o     <= (s1_req_q.length > fpm_pkg::MaxFrame);
      end else begin
        forward_o      <= 1'b0;
        port_number_o  <= '0;
        seconds_o      <= '0;
        microseconds_o <= '0;
        data_length_o  <= '0;
        oversize_o     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_vld_q <= head_valid_i;
      end
      if (s2_load) begin
        s2_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        s2_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = s2_vld_q;

endmodule

[rtl/mirror_port_failover_monitor_unit.sv]
// ----------------------------------------------------------------------------
// Mirror port failover monitor
// Active/standby link monitor with ERF timestamp conversion.
// ----------------------------------------------------------------------------
// Each request is a captured record or a one-second tick, and every request
// yields exactly one result. A record marks its port as seen and, when its
// port is active, is forwarded with its ERF stamp split into seconds and
// rounded microseconds plus an oversize flag above 1518 bytes; a standby
// record or a tick returns all-zero record fields. A tick checks port 0
// then port 1: an idle port counts a miss (saturating at 31), turns
// critical past miss_limit, and an active critical port hands over to a
// healthy peer; a busy port returns to normal. Every result carries both
// ports' status after its request. The block takes one request per cycle
// while in_stall_o is low: the front updates port state in the accept
// cycle and queues the request, and the back multiplies the fraction by
// one million in one stage and rounds in the next, which registers the
// result onto out_valid_o. A two-entry queue decouples the sides, so a
// receiver stall backs up into in_stall_o only once the queue fills. The
// user writes miss_limit (reset 2) through miss_limit_we_i only while idle; the block does not enforce this.
module mirror_port_failover_monitor_unit #(
  parameter int unsigned QueueDepth = fpm_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        miss_limit_we_i,
  input  logic [3:0]  miss_limit_wdata_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic        iface_i,
  input  logic [63:0] record_stamp_i,
  input  logic [15:0] capture_length_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        forward_o,
  output logic [1:0]  port_number_o,
  output logic [31:0] seconds_o,
  output logic [19:0] microseconds_o,
  output logic [15:0] data_length_o,
  output logic        oversize_o,
  output logic        port0_critical_o,
  output logic        port1_critical_o,
  output logic        port0_active_o,
  output logic        port1_active_o
);

  fpm_pkg::req_t  front_req, head_req;
  fpm_pkg::stat_t stat;
  logic           take, q_full, q_nonempty, q_pop;

  // accept whenever the queue has room
  assign in_stall_o = q_full;
  assign take       = in_valid_i && !q_full;

  fpm_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .miss_limit_we_i    (miss_limit_we_i),
    .miss_limit_wdata_i (miss_limit_wdata_i),
    .take_i             (take),
    .command_i          (command_i),
    .iface_i            (iface_i),
    .record_stamp_i     (record_stamp_i),
    .capture_length_i   (capture_length_i),
    .req_o              (front_req)
  );

  fpm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (take),
    .push_req_i (front_req),
    .pop_i      (q_pop),
    .full_o     (q_full),
    .nonempty_o (q_nonempty),
    .head_o     (head_req)
  );

  fpm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (q_nonempty),
    .head_i         (head_req),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .forward_o      (forward_o),
    .port_number_o  (port_number_o),
    .seconds_o      (seconds_o),
    .microseconds_o (microseconds_o),
    .data_length_o  (data_length_o),
    .oversize_o     (oversize_o),
    .stat_o         (stat)
  );

  // unpack the status snapshot onto the per-port flags
  assign port0_critical_o = stat.crit[0];
  assign port1_critical_o = stat.crit[1];
  assign port0_active_o   = stat.active[0];
  assign port1_active_o   = stat.active[1];

endmodule

[rtl/fpm_checker.sv]
// ----------------------------------------------------------------------------
// Failover monitor checker
// Port-level assertions on results of the failover monitor.
// ----------------------------------------------------------------------------
`include "mirror_port_failover_monitor_unit_defines.svh"

module fpm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        forward_o,
  input logic [1:0]  port_number_o,
  input logic [31:0] seconds_o,
  input logic [19:0] microseconds_o,
  input logic [15:0] data_length_o,
  input logic        oversize_o,
  input logic        port0_active_o,
  input logic        port1_active_o
);

  // exactly one port is active in every valid result
  `FPM_ASSERT_NOW(one_active_a, clk_i, rst_ni, out_valid_o, (port0_active_o ^ port1_active_o))

  // a result that is not forwarded has all record fields zero
  `FPM_ASSERT_NOW(drop_zero_a, clk_i, rst_ni, out_valid_o && !forward_o, (port_number_o == 2'd0) && (seconds_o == 32'd0) && (microseconds_o == 20'd0) && (data_length_o == 16'd0) && !oversize_o)

  // rounding carry keeps microseconds in range and port numbers valid
  `FPM_ASSERT_NOW(fwd_range_a, clk_i, rst_ni, out_valid_o && forward_o, (microseconds_o < 20'd1000000) && ((port_number_o == 2'd1) || (port_number_o == 2'd2)))

  // a stalled result holds
  `FPM_ASSERT_NEXT(hold_a, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(seconds_o) && $stable(microseconds_o) && $stable(forward_o))

endmodule

bind mirror_port_failover_monitor_unit fpm_checker u_fpm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .forward_o      (forward_o),
  .port_number_o  (port_number_o),
  .seconds_o      (seconds_o),
  .microseconds_o (microseconds_o),
  .data_length_o  (data_length_o),
  .oversize_o     (oversize_o),
  .port0_active_o (port0_active_o),
  .port1_active_o (port1_active_o)
);
